>>> rtl/core/hbbd_pkg.sv
package hbbd_pkg;

   // default geometry of the directory
   localparam int BUCKETS_DEFAULT = 13;
   localparam int WAYS_DEFAULT    = 8;

   // hash: (dev * HASH_MULT + block) mod 2^32, then mod bucket count
   localparam int HASH_W    = 32;
   localparam int HASH_MULT = 300;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // request kinds
   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_PIN     = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_HIT       = 2'd0,
      STATUS_MISS      = 2'd1,
      STATUS_NO_FREE   = 2'd2,
      STATUS_RANGE_ERR = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  dev;
      logic [31:0] block_number;
      logic [2:0]  way;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] bucket;
      logic [2:0] slot;
      logic       needs_read;
      logic [7:0] count_after;
   } rsp_type;

   // one directory entry as stored in a bucket row
   typedef struct packed {
      logic [7:0]  dev;
      logic [31:0] blk;
      logic        valid;
      logic [7:0]  count;
   } entry_type;

endpackage

>>> rtl/core/hashed_block_buffer_directory.sv
// channel   direction  ports                          payload
// request   in         req_valid, req_stall, req_data  hbbd_pkg::req_type
// response  out        rsp_valid, rsp_stall, rsp_data  hbbd_pkg::rsp_type
//
// an item is taken only once the last one is through: the hash bytes are
// folded at the accepting edge, then the quotient, the remainder and the bucket
// row read are registered in turn, then the row is updated and the result
// registered; the request side opens again in the cycle after.
// reset clears the row valid bits at once, so no clearing pass is needed.
// a result waiting under rsp_stall does not block the next request; that item
// waits in its update step until the response register frees.
module hashed_block_buffer_directory #(
   parameter int BUCKETS = hbbd_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = hbbd_pkg::WAYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hbbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hbbd_pkg::rsp_type rsp_data
);

   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int EW    = $bits(hbbd_pkg::entry_type);
   localparam int ROW_W = WAYS * EW;

   hbbd_pkg::state_type state_ff, state_in;

   logic [1:0]                  kind_ff;
   logic [7:0]                  dev_ff;
   logic [31:0]                 blk_ff;
   logic [2:0]                  way_ff;
   logic [BW-1:0]               bucket_ff, bucket_in;
   logic [BUCKETS-1:0]          row_valid_ff, row_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   hbbd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        req_accept;
   logic                        mod_done;
   logic [BW-1:0]               mod_rem;
   logic [hbbd_pkg::HASH_W-1:0] hash;
   logic                        rd_en;
   logic [ROW_W-1:0]            rd_data;
   logic                        exec_go;
   logic                        wr_need;

   hbbd_pkg::entry_type [WAYS-1:0] row_q;
   hbbd_pkg::entry_type [WAYS-1:0] row_in;
   hbbd_pkg::rsp_type              result;

   logic                hit_found, free_found;
   logic [WW-1:0]       hit_idx, free_idx, way_idx;
   logic                way_ok;

   assign req_accept = req_valid && !req_stall;

   // hash of the incoming item, wraps at 32 bits
   assign hash = hbbd_pkg::HASH_W'(req_data.dev * 17'(hbbd_pkg::HASH_MULT))
               + req_data.block_number;

   hbbd_bucket_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .value     (hash),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hbbd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (exec_go && wr_need),
      .wr_addr (bucket_ff),
      .wr_data (row_in),
      .rd_en   (rd_en),
      .rd_addr (mod_rem),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbbd_pkg::ST_IDLE: begin
            if (req_valid) state_in = hbbd_pkg::ST_MOD;
         end
         hbbd_pkg::ST_MOD: begin
            if (mod_done) state_in = hbbd_pkg::ST_EXEC;
         end
         hbbd_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = hbbd_pkg::ST_IDLE;
         end
         default: state_in = hbbd_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         hbbd_pkg::ST_IDLE: req_stall = 1'b0;
         hbbd_pkg::ST_MOD:  rd_en = mod_done;
         hbbd_pkg::ST_EXEC: exec_go = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   // a row never written reads as all zero
   assign row_q = row_valid_ff[bucket_ff] ? rd_data : '0;

   // first matching way and first way with a zero count
   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (row_q[i].dev == dev_ff && row_q[i].blk == blk_ff) begin
            hit_found = 1'b1;
            hit_idx   = WW'(i);
         end
         if (row_q[i].count == 8'd0) begin
            free_found = 1'b1;
            free_idx   = WW'(i);
         end
      end
   end

   assign way_ok  = 32'(way_ff) < 32'(WAYS);
   assign way_idx = WW'(way_ff);

   // row update and result
   always_comb begin
      row_in             = row_q;
      wr_need            = 1'b0;
      result.status      = hbbd_pkg::STATUS_RANGE_ERR;
      result.bucket      = 4'(bucket_ff);
      result.slot        = way_ff;
      result.needs_read  = 1'b0;
      result.count_after = 8'd0;
      case (kind_ff)
         hbbd_pkg::KIND_GET: begin
            if (hit_found) begin
               result.slot = 3'(hit_idx);
               if (row_q[hit_idx].count == hbbd_pkg::COUNT_MAX) begin
                  result.count_after = hbbd_pkg::COUNT_MAX;
               end else begin
                  row_in[hit_idx].count = row_q[hit_idx].count + 8'd1;
                  row_in[hit_idx].valid = 1'b1;
                  wr_need               = 1'b1;
                  result.status         = hbbd_pkg::STATUS_HIT;
                  result.needs_read     = !row_q[hit_idx].valid;
                  result.count_after    = row_q[hit_idx].count + 8'd1;
               end
            end else if (free_found) begin
               row_in[free_idx].dev   = dev_ff;
               row_in[free_idx].blk   = blk_ff;
               row_in[free_idx].count = 8'd1;
               row_in[free_idx].valid = 1'b1;
               wr_need                = 1'b1;
               result.status          = hbbd_pkg::STATUS_MISS;
               result.slot            = 3'(free_idx);
               result.needs_read      = 1'b1;
               result.count_after     = 8'd1;
            end else begin
               result.status = hbbd_pkg::STATUS_NO_FREE;
               result.slot   = 3'd0;
            end
         end
         hbbd_pkg::KIND_PIN: begin
            if (way_ok) begin
               if (row_q[way_idx].count == hbbd_pkg::COUNT_MAX) begin
                  result.count_after = hbbd_pkg::COUNT_MAX;
               end else begin
                  row_in[way_idx].count = row_q[way_idx].count + 8'd1;
                  wr_need               = 1'b1;
                  result.status         = hbbd_pkg::STATUS_HIT;
                  result.count_after    = row_q[way_idx].count + 8'd1;
               end
            end
         end
         hbbd_pkg::KIND_RELEASE: begin
            if (way_ok && row_q[way_idx].count != 8'd0) begin
               row_in[way_idx].count = row_q[way_idx].count - 8'd1;
               wr_need               = 1'b1;
               result.status         = hbbd_pkg::STATUS_HIT;
               result.count_after    = row_q[way_idx].count - 8'd1;
            end
         end
         default: begin
            result.status = hbbd_pkg::STATUS_RANGE_ERR;
         end
      endcase
   end

   // bucket, row valid bits and response register
   always_comb begin
      bucket_in    = bucket_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rd_en) begin
         bucket_in = mod_rem;
      end
      if (exec_go) begin
         if (wr_need) row_valid_in[bucket_ff] = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbbd_pkg::ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request fields held for the whole operation
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_data.kind;
         dev_ff  <= req_data.dev;
         blk_ff  <= req_data.block_number;
         way_ff  <= req_data.way;
      end
      bucket_ff   <= bucket_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/hbbd_ram.sv
module hbbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hbbd_bucket_mod.sv
module hbbd_bucket_mod #(
   parameter int BUCKETS = hbbd_pkg::BUCKETS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [hbbd_pkg::HASH_W-1:0]                  value,
   output logic                                         done,
   output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] remainder
);

   localparam int BW          = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FOLD_W      = 16;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = FOLD_W + RECIP_W;

   // weights of the upper hash bytes modulo the bucket count
   localparam logic [FOLD_W-1:0] W8  = FOLD_W'(256 % BUCKETS);
   localparam logic [FOLD_W-1:0] W16 = FOLD_W'(65536 % BUCKETS);
   localparam logic [FOLD_W-1:0] W24 = FOLD_W'(16777216 % BUCKETS);

   // reciprocal of the bucket count, exact for any folded value
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + BUCKETS - 1) / BUCKETS);

   logic [FOLD_W-1:0] fold_ff, fold_in;
   logic [FOLD_W-1:0] quot_ff, quot_in;
   logic [FOLD_W-1:0] num_ff;
   logic [BW-1:0]     rem_ff, rem_in;
   logic              fold_vld_ff, quot_vld_ff, done_ff;
   logic [PROD_W-1:0] prod;
   logic [FOLD_W-1:0] back;

   // fold the bytes, then divide by reciprocal and take the remainder
   always_comb begin
      fold_in = FOLD_W'(value[7:0])
              + FOLD_W'(value[15:8]) * W8
              + FOLD_W'(value[23:16]) * W16
              + FOLD_W'(value[31:24]) * W24;
      prod    = PROD_W'(fold_ff) * PROD_W'(RECIP);
      quot_in = prod[RECIP_SHIFT +: FOLD_W];
      back    = FOLD_W'(quot_ff * FOLD_W'(BUCKETS));
      rem_in  = BW'(num_ff - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_vld_ff <= 1'b0;
         quot_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         fold_vld_ff <= start;
         quot_vld_ff <= fold_vld_ff;
         done_ff     <= quot_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         fold_ff <= fold_in;
      end
      if (fold_vld_ff) begin
         quot_ff <= quot_in;
         num_ff  <= fold_ff;
      end
      if (quot_vld_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   import hbbd_pkg::*;

   localparam int unsigned NUM_BUCKETS = 13;
   localparam int unsigned NUM_WAYS    = 8;
   localparam int unsigned HASH_SCALE  = 300;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int POOL_SIZE     = 33;
   localparam int FILL_BUCKET   = 5;
   localparam int MAX_CYCLES    = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLDOFF_LEN   = 300;

   // shadow directory: predicts every result and tracks what is still due
   class dir_scoreboard;
      bit [7:0]  tag_dev [NUM_BUCKETS*NUM_WAYS];
      bit [31:0] tag_blk [NUM_BUCKETS*NUM_WAYS];
      bit        filled  [NUM_BUCKETS*NUM_WAYS];
      bit [7:0]  ref_count [NUM_BUCKETS*NUM_WAYS];
      rsp_type   outcomes_due [$];
      int        mismatches;
      int        checked;
      int        status_seen [4];

      static function int bucket_of(logic [7:0] dev, logic [31:0] blk);
         logic [31:0] h;
         h = 32'(dev) * 32'(HASH_SCALE) + blk;
         return int'(h % NUM_BUCKETS);
      endfunction

      function int resident_way(logic [7:0] dev, logic [31:0] blk);
         int base;
         base = bucket_of(dev, blk) * NUM_WAYS;
         for (int i = 0; i < NUM_WAYS; i++) begin
            if (tag_dev[base+i] == dev && tag_blk[base+i] == blk) return i;
         end
         return -1;
      endfunction

      // apply one request to the shadow directory and return its result
      function rsp_type dir_outcome(req_type r);
         int bkt, e, hit_way, free_way, i;
         rsp_type o;
         bkt = bucket_of(r.dev, r.block_number);
         o = '0;
         o.bucket = 4'(bkt);
         case (r.kind)
            KIND_GET: begin
               hit_way = resident_way(r.dev, r.block_number);
               free_way = -1;
               for (i = NUM_WAYS - 1; i >= 0; i--) begin
                  if (ref_count[bkt*NUM_WAYS+i] == 0) free_way = i;
               end
               if (hit_way >= 0) begin
                  e = bkt * NUM_WAYS + hit_way;
                  o.slot = 3'(hit_way);
                  if (ref_count[e] == COUNT_MAX) begin
                     o.status = STATUS_RANGE_ERR;
                     o.count_after = COUNT_MAX;
                  end else begin
                     ref_count[e]++;
                     o.needs_read = !filled[e];
                     filled[e] = 1'b1;
                     o.status = STATUS_HIT;
                     o.count_after = ref_count[e];
                  end
               end else if (free_way >= 0) begin
                  // claim the first unreferenced way; the read fills it
                  e = bkt * NUM_WAYS + free_way;
                  tag_dev[e] = r.dev;
                  tag_blk[e] = r.block_number;
                  ref_count[e] = 8'd1;
                  filled[e] = 1'b1;
                  o.status = STATUS_MISS;
                  o.slot = 3'(free_way);
                  o.needs_read = 1'b1;
                  o.count_after = 8'd1;
               end else begin
                  o.status = STATUS_NO_FREE;
               end
            end
            KIND_PIN, KIND_RELEASE: begin
               e = bkt * NUM_WAYS + r.way;
               o.slot = r.way;
               if (r.kind == KIND_PIN && ref_count[e] == COUNT_MAX) begin
                  o.status = STATUS_RANGE_ERR;
                  o.count_after = COUNT_MAX;
               end else if (r.kind == KIND_RELEASE && ref_count[e] == 0) begin
                  o.status = STATUS_RANGE_ERR;
               end else begin
                  if (r.kind == KIND_PIN) ref_count[e]++;
                  else ref_count[e]--;
                  o.status = STATUS_HIT;
                  o.count_after = ref_count[e];
               end
            end
            default: begin
               o.status = STATUS_RANGE_ERR;
               o.slot = r.way;
            end
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         outcomes_due.push_back(dir_outcome(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (outcomes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result with nothing due: status %0d bucket %0d slot %0d read %0b count %0d",
                        got.status, got.bucket, got.slot, got.needs_read, got.count_after);
            return;
         end
         want = outcomes_due.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.status !== want.status || got.bucket !== want.bucket ||
             got.slot !== want.slot || got.needs_read !== want.needs_read ||
             got.count_after !== want.count_after) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: expected status %0d bucket %0d slot %0d read %0b count %0d",
                        checked, want.status, want.bucket, want.slot, want.needs_read,
                        want.count_after,
                        "\n   got status %0d bucket %0d slot %0d read %0b count %0d",
                        got.status, got.bucket, got.slot, got.needs_read, got.count_after);
         end
      endfunction

      function int outstanding();
         return outcomes_due.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   dir_scoreboard sb = new;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int holdoff_left  = 0;
   int requests_sent = 0;
   int cycles        = 0;
   logic [7:0]  pool_dev [POOL_SIZE];
   logic [31:0] pool_blk [POOL_SIZE];

   hashed_block_buffer_directory dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: check accepted items, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // run limit
   initial begin
      while (cycles < MAX_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("run limit of %0d cycles reached with %0d results still due",
               MAX_CYCLES, sb.outstanding());
      $display("[hashed_block_buffer_directory] ERROR");
      $finish;
   end

   // offer one item, with random idle cycles ahead of it, until accepted
   task automatic send_item(input req_type r);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      requests_sent++;
   endtask

   task automatic send_op(input logic [1:0] kind, input logic [7:0] dev,
                          input logic [31:0] blk, input logic [2:0] way);
      req_type r;
      r.kind = kind;
      r.dev = dev;
      r.block_number = blk;
      r.way = way;
      send_item(r);
   endtask

   // stop offering and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic tag_in_bucket(input int bkt, output logic [7:0] dev,
                                output logic [31:0] blk);
      do begin
         dev = 8'($urandom);
         blk = $urandom;
      end while (dir_scoreboard::bucket_of(dev, blk) != bkt);
   endtask

   // mostly gets and releases on a few crowded buckets, some noise
   task automatic send_random_request();
      int pick, t, w, base, start, k;
      logic [7:0]  dev;
      logic [31:0] blk;
      pick = $urandom_range(99, 0);
      t = $urandom_range(POOL_SIZE - 1, 0);
      dev = pool_dev[t];
      blk = pool_blk[t];
      w = $urandom_range(NUM_WAYS - 1, 0);
      if (pick < 40) begin
         if (pick < 5) begin
            dev = 8'($urandom);
            blk = $urandom;
         end
         send_op(KIND_GET, dev, blk, 3'(w));
      end else if (pick < 80) begin
         // release a referenced way of the bucket when there is one
         base = dir_scoreboard::bucket_of(dev, blk) * NUM_WAYS;
         start = w;
         for (k = 0; k < NUM_WAYS; k++) begin
            if (sb.ref_count[base + (start + k) % NUM_WAYS] != 0) begin
               w = (start + k) % NUM_WAYS;
               break;
            end
         end
         send_op(KIND_RELEASE, dev, blk, 3'(w));
      end else if (pick < 88) begin
         send_op(KIND_PIN, dev, blk, 3'(w));
      end else if (pick < 93) begin
         send_op(KIND_UNUSED, 8'($urandom), $urandom, 3'(w));
      end else begin
         send_op(pick[0] ? KIND_PIN : KIND_RELEASE, 8'($urandom), $urandom, 3'(w));
      end
   endtask

   initial begin
      int k, w;
      logic [7:0]  fill_dev [9];
      logic [31:0] fill_blk [9];

      // tag pool spread over three buckets, more tags than ways in each
      for (k = 0; k < POOL_SIZE; k++) tag_in_bucket((k % 3) * 4 + 2, pool_dev[k], pool_blk[k]);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zeroed tag hit, release down to zero and below
      send_op(KIND_GET, 8'h00, 32'h0000_0000, 3'd0);
      send_op(KIND_GET, 8'h00, 32'h0000_0000, 3'd0);
      send_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 3'd0);
      send_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 3'd0);
      send_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 3'd0);
      send_op(KIND_PIN, 8'h00, 32'h0000_0000, 3'd7);
      send_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 3'd7);
      // unused kind, all-ones fields with hash wrap
      send_op(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 3'd5);
      send_op(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 3'd7);
      send_op(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 3'd0);
      w = sb.resident_way(8'hFF, 32'hFFFF_FFFF);
      send_op(KIND_PIN, 8'hFF, 32'hFFFF_FFFF, 3'(w));
      send_op(KIND_GET, 8'h01, 32'h8000_0000, 3'd2);
      // fill one bucket past its ways
      for (k = 0; k < 9; k++) begin
         tag_in_bucket(FILL_BUCKET, fill_dev[k], fill_blk[k]);
         send_op(KIND_GET, fill_dev[k], fill_blk[k], 3'(k));
      end
      send_op(KIND_GET, fill_dev[0], fill_blk[0], 3'd0);
      send_op(KIND_RELEASE, fill_dev[3], fill_blk[3], 3'd3);
      drain();

      // random traffic under each idle mix
      for (k = 0; k < 4; k++) begin
         case (k)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         repeat (55) send_random_request();
         drain();
      end

      // receiver holds off while the sender keeps offering
      idle_pct = 0;
      stall_pct = 0;
      holdoff_left = HOLDOFF_LEN;
      repeat (24) send_random_request();
      drain();

      // drive one entry's count into saturation
      idle_pct = 16;
      stall_pct = 16;
      send_op(KIND_GET, 8'h00, 32'h0000_0000, 3'd0);
      w = sb.resident_way(8'h00, 32'h0000_0000);
      if (w < 0) w = 0;
      repeat (258) begin
         if ($urandom_range(4, 0) == 0) send_op(KIND_GET, 8'h00, 32'h0000_0000, 3'(w));
         else send_op(KIND_PIN, 8'h00, 32'h0000_0000, 3'(w));
      end
      repeat (4) send_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 3'(w));
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests, %0d results: %0d hit or done, %0d miss, %0d no free, %0d refused",
               requests_sent, sb.checked, sb.status_seen[STATUS_HIT],
               sb.status_seen[STATUS_MISS], sb.status_seen[STATUS_NO_FREE],
               sb.status_seen[STATUS_RANGE_ERR]);
      $display("idle mixes on both sides, long receiver hold-off, count saturation; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[hashed_block_buffer_directory] OK");
      end else begin
         $display("[hashed_block_buffer_directory] ERROR");
      end
      $finish;
   end

endmodule
